>>> src/obcp_pkg.sv
`default_nettype none
package obcp_pkg;
    localparam int CoordBits = 16;
    localparam int QuatBits  = 16;
    localparam int QuatFrac  = 14;
    localparam int DistBits  = 34;
    localparam int MatBits   = 34;
    localparam int DiffBits  = CoordBits + 1;
    localparam int ProdBits  = MatBits + DiffBits;
    localparam int AccBits   = ProdBits + 2;
    localparam int PBits     = AccBits - 2 * QuatFrac;
    localparam int FaceBits  = 2 * PBits + 4;
    localparam int CfgBits   = 64;

    typedef enum logic [1:0] {
        REG_CENTER   = 2'd0,
        REG_ROTATION = 2'd1,
        REG_HALF     = 2'd2,
        REG_RADIUS   = 2'd3
    } t_reg_idx;
endpackage
`default_nettype wire

>>> src/oriented_box_closest_point.sv
// Closest point on one oriented box.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx at once
// (0 center, 1 rotation quaternion, 2 half extents, 3 reject radius squared).
// Write registers only while no query is in flight.
// Queries: a transaction is accepted at each edge where i_start is high and
// o_busy is low. o_busy is high for one cycle after reset and for one cycle
// after each rotation write, while the registered matrix catches up.
// Results: o_done is high for one cycle with all result fields valid.
// Throughput: one query per cycle while o_busy is low.
// The matrix build (two register stages) runs beside the query pipeline of
// offsets, box-space rotation, clamps, face search, rotation back, output.
// Reset clears all valid bits and loads the identity rotation; the
// receiver cannot stall, so every result is shown exactly once.
`default_nettype none
module oriented_box_closest_point
    import obcp_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_idx,
    input  wire logic [CfgBits-1:0]         i_cfg_data,
    input  wire logic                       i_start,
    output logic                            o_busy,
    input  wire logic signed [CoordBits-1:0] i_query_x,
    input  wire logic signed [CoordBits-1:0] i_query_y,
    input  wire logic signed [CoordBits-1:0] i_query_z,
    output logic                            o_done,
    output logic                            o_hit_valid,
    output logic                            o_is_inside,
    output logic signed [CoordBits-1:0]     o_near_x,
    output logic signed [CoordBits-1:0]     o_near_y,
    output logic signed [CoordBits-1:0]     o_near_z,
    output logic [DistBits-1:0]             o_dist_sq
);
    localparam int Lat = 8;
    localparam logic signed [MatBits-1:0] OneM = MatBits'(1) <<< (2 * QuatFrac);
    localparam logic signed [AccBits-1:0] Half = AccBits'(1) <<< (2 * QuatFrac - 1);
    localparam logic [DistBits-1:0] DistMax = '1;

    logic [47:0] r_center, r_half;
    logic [63:0] r_rot;
    logic [DistBits-1:0] r_radius;
    logic r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_rot    <= 64'd16384;
            r_half   <= '0;
            r_radius <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_CENTER:   r_center <= i_cfg_data[47:0];
                REG_ROTATION: r_rot    <= i_cfg_data;
                REG_HALF:     r_half   <= i_cfg_data[47:0];
                REG_RADIUS:   r_radius <= i_cfg_data[DistBits-1:0];
                default:      r_center <= r_center;
            endcase
        end
    end

    // The matrix lags the rotation register by the product and matrix registers,
    // so a query may not enter in the cycle right after a rotation change.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_busy <= 1'b1;
        else          r_busy <= i_cfg_we && (t_reg_idx'(i_cfg_idx) == REG_ROTATION);
    end

    // Matrix from the quaternion, registered (config is static during use).
    logic signed [QuatBits-1:0] qw, qx, qy, qz;
    assign qw = r_rot[15:0];
    assign qx = r_rot[31:16];
    assign qy = r_rot[47:32];
    assign qz = r_rot[63:48];
    logic signed [2*QuatBits-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    always_ff @(posedge i_clk) begin
        r_xx <= qx * qx; r_yy <= qy * qy; r_zz <= qz * qz;
        r_xy <= qx * qy; r_xz <= qx * qz; r_yz <= qy * qz;
        r_wx <= qw * qx; r_wy <= qw * qy; r_wz <= qw * qz;
    end
    logic signed [MatBits-1:0] r_m [3][3];
    function automatic logic signed [MatBits-1:0] tw(input logic signed [2*QuatBits-1:0] a,
                                                     input logic signed [2*QuatBits-1:0] b);
        logic signed [MatBits-1:0] s;
        s = MatBits'(a) + MatBits'(b);
        return s <<< 1;
    endfunction
    always_ff @(posedge i_clk) begin
        r_m[0][0] <= OneM - tw(r_yy, r_zz);
        r_m[0][1] <= tw(r_xy, -r_wz);
        r_m[0][2] <= tw(r_xz, r_wy);
        r_m[1][0] <= tw(r_xy, r_wz);
        r_m[1][1] <= OneM - tw(r_xx, r_zz);
        r_m[1][2] <= tw(r_yz, -r_wx);
        r_m[2][0] <= tw(r_xz, -r_wy);
        r_m[2][1] <= tw(r_yz, r_wx);
        r_m[2][2] <= OneM - tw(r_xx, r_yy);
    end

    logic signed [CoordBits-1:0] cen [3];
    logic signed [PBits-1:0] hh [3];
    for (genvar k = 0; k < 3; k++) begin : g_cfg
        assign cen[k] = r_center[k*CoordBits +: CoordBits];
        assign hh[k]  = PBits'({1'b0, r_half[k*CoordBits +: CoordBits]});
    end

    // Stage 1: offsets.
    logic [Lat-1:0] r_v;
    logic signed [CoordBits-1:0] r1_q [3];
    logic signed [DiffBits-1:0] r1_d [3];
    always_ff @(posedge i_clk) begin
        r1_q[0] <= i_query_x; r1_q[1] <= i_query_y; r1_q[2] <= i_query_z;
        r1_d[0] <= DiffBits'(i_query_x) - DiffBits'(cen[0]);
        r1_d[1] <= DiffBits'(i_query_y) - DiffBits'(cen[1]);
        r1_d[2] <= DiffBits'(i_query_z) - DiffBits'(cen[2]);
    end

    // Stage 2: squares and rotation products.
    logic signed [CoordBits-1:0] r2_q [3];
    logic [2*DiffBits-1:0] r2_sq [3];
    logic signed [ProdBits-1:0] r2_pr [3][3];
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r2_q[i]  <= r1_q[i];
            r2_sq[i] <= unsigned'((2*DiffBits)'(r1_d[i]) * (2*DiffBits)'(r1_d[i]));
            for (int j = 0; j < 3; j++)
                r2_pr[i][j] <= ProdBits'(r_m[i][j]) * ProdBits'(r1_d[j]);
        end
    end

    // Stage 3: reject test and box-space point.
    logic signed [CoordBits-1:0] r3_q [3];
    logic r3_rej;
    logic signed [PBits-1:0] r3_p [3];
    logic [DistBits-1:0] mag;
    assign mag = DistBits'(r2_sq[0]) + DistBits'(r2_sq[1]) + DistBits'(r2_sq[2]);
    always_ff @(posedge i_clk) begin
        logic signed [AccBits-1:0] acc;
        r3_rej <= mag > r_radius;
        for (int i = 0; i < 3; i++) begin
            r3_q[i] <= r2_q[i];
            acc = AccBits'(r2_pr[i][0]) + AccBits'(r2_pr[i][1]) + AccBits'(r2_pr[i][2]) + Half;
            r3_p[i] <= PBits'(acc >>> (2 * QuatFrac));
        end
    end

    // Stage 4: inside test and per-axis clamps and squared gaps.
    logic signed [CoordBits-1:0] r4_q [3];
    logic r4_rej, r4_in;
    logic signed [PBits-1:0] r4_cl [3];
    logic [FaceBits-1:0] r4_gc [3], r4_gn [3], r4_gp [3];
    always_ff @(posedge i_clk) begin
        logic signed [PBits:0] e;
        logic allin;
        allin = 1'b1;
        r4_rej <= r3_rej;
        for (int i = 0; i < 3; i++) begin
            r4_q[i] <= r3_q[i];
            if (r3_p[i] < -hh[i] || r3_p[i] > hh[i]) allin = 1'b0;
            r4_cl[i] <= (r3_p[i] < -hh[i]) ? -hh[i] : ((r3_p[i] > hh[i]) ? hh[i] : r3_p[i]);
            e = (r3_p[i] < -hh[i]) ? (PBits+1)'(-hh[i]) - (PBits+1)'(r3_p[i])
              : ((r3_p[i] > hh[i]) ? (PBits+1)'(hh[i]) - (PBits+1)'(r3_p[i]) : '0);
            r4_gc[i] <= unsigned'(FaceBits'(e) * FaceBits'(e));
            e = (PBits+1)'(-hh[i]) - (PBits+1)'(r3_p[i]);
            r4_gn[i] <= unsigned'(FaceBits'(e) * FaceBits'(e));
            e = (PBits+1)'(hh[i]) - (PBits+1)'(r3_p[i]);
            r4_gp[i] <= unsigned'(FaceBits'(e) * FaceBits'(e));
        end
        r4_in <= allin;
    end

    // Stage 5: face search, ties go to the earlier face.
    logic signed [CoordBits-1:0] r5_q [3];
    logic r5_rej, r5_in;
    logic signed [PBits-1:0] r5_b [3];
    logic [FaceBits-1:0] r5_bd;
    always_ff @(posedge i_clk) begin
        logic [FaceBits-1:0] dd, bd;
        logic [2:0] bf;
        bd = '0; bf = '0;
        for (int f = 0; f < 6; f++) begin
            dd = '0;
            for (int i = 0; i < 3; i++)
                dd = dd + ((i == f / 2) ? ((f % 2 == 1) ? r4_gp[i] : r4_gn[i]) : r4_gc[i]);
            if (f == 0 || dd < bd) begin
                bd = dd; bf = 3'(f);
            end
        end
        for (int i = 0; i < 3; i++)
            r5_b[i] <= (int'(bf[2:1]) == i) ? (bf[0] ? hh[i] : -hh[i]) : r4_cl[i];
        r5_bd  <= bd;
        r5_rej <= r4_rej;
        r5_in  <= r4_in;
        for (int i = 0; i < 3; i++) r5_q[i] <= r4_q[i];
    end

    // Stage 6: back-rotation products.
    logic signed [CoordBits-1:0] r6_q [3];
    logic r6_rej, r6_in;
    logic [FaceBits-1:0] r6_bd;
    logic signed [ProdBits-1:0] r6_pr [3][3];
    always_ff @(posedge i_clk) begin
        r6_rej <= r5_rej; r6_in <= r5_in; r6_bd <= r5_bd;
        for (int i = 0; i < 3; i++) begin
            r6_q[i] <= r5_q[i];
            for (int j = 0; j < 3; j++)
                r6_pr[i][j] <= ProdBits'(r_m[j][i]) * ProdBits'(r5_b[j]);
        end
    end

    // Stage 7: sum, round, move back to world space.
    logic signed [CoordBits-1:0] r7_q [3];
    logic r7_rej, r7_in;
    logic [FaceBits-1:0] r7_bd;
    logic signed [PBits+1:0] r7_w [3];
    always_ff @(posedge i_clk) begin
        logic signed [AccBits-1:0] acc;
        r7_rej <= r6_rej; r7_in <= r6_in; r7_bd <= r6_bd;
        for (int i = 0; i < 3; i++) begin
            r7_q[i] <= r6_q[i];
            acc = AccBits'(r6_pr[i][0]) + AccBits'(r6_pr[i][1]) + AccBits'(r6_pr[i][2]) + Half;
            r7_w[i] <= (PBits+2)'(acc >>> (2 * QuatFrac)) + (PBits+2)'(cen[i]);
        end
    end

    function automatic logic signed [CoordBits-1:0] sat(input logic signed [PBits+1:0] v);
        logic signed [PBits+1:0] hi, lo;
        hi = (PBits+2)'((64'sd1 <<< (CoordBits - 1)) - 1);
        lo = -hi - 1;
        return (v > hi) ? CoordBits'(hi) : ((v < lo) ? CoordBits'(lo) : CoordBits'(v));
    endfunction

    // Stage 8: output register.
    always_ff @(posedge i_clk) begin
        if (r7_rej) begin
            o_hit_valid <= 1'b0; o_is_inside <= 1'b0;
            o_near_x <= '0; o_near_y <= '0; o_near_z <= '0;
            o_dist_sq <= DistMax;
        end else if (r7_in) begin
            o_hit_valid <= 1'b1; o_is_inside <= 1'b1;
            o_near_x <= r7_q[0];
            o_near_y <= sat((PBits+2)'(r7_q[1]) + (PBits+2)'(16));
            o_near_z <= r7_q[2];
            o_dist_sq <= '0;
        end else begin
            o_hit_valid <= 1'b1; o_is_inside <= 1'b0;
            o_near_x <= sat(r7_w[0]);
            o_near_y <= sat(r7_w[1]);
            o_near_z <= sat(r7_w[2]);
            o_dist_sq <= (r7_bd > FaceBits'(DistMax)) ? DistMax : DistBits'(r7_bd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else          r_v <= {r_v[Lat-2:0], i_start & ~r_busy};
    end
    assign o_done = r_v[Lat-1];
    assign o_busy = r_busy;
endmodule
`default_nettype wire

>>> src/obcp_checker.sv
`default_nettype none
module obcp_checker
    import obcp_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic o_busy,
    input wire logic o_done,
    input wire logic o_hit_valid,
    input wire logic o_is_inside,
    input wire logic [DistBits-1:0] o_dist_sq
);
    a_start_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##8 o_done) else $error("missing result");
    a_inside_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_is_inside) |-> (o_hit_valid && o_dist_sq == '0)) else $error("inside");
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit_valid) |-> (o_dist_sq == '1 && !o_is_inside)) else $error("reject");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_rst_n, 8)) |-> $past(i_start, 8)) else $error("spurious");
endmodule

bind oriented_box_closest_point obcp_checker u_chk (.*);
`default_nettype wire
